/* design/gaussian_rbf_kernel_eval_macros.svh */
// Assertion macros shared by the Gaussian RBF kernel evaluator modules.
`ifndef GAUSSIAN_RBF_KERNEL_EVAL_MACROS_SVH
`define GAUSSIAN_RBF_KERNEL_EVAL_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define RBF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be seen at a clock edge out of reset.
`define RBF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBF_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* design/rbf_pkg.sv */
// Types, constants and exp table function for the Gaussian RBF kernel evaluator.
package rbf_pkg;

  localparam int unsigned ELEM_BITS_DEF      = 16;
  localparam int unsigned MAX_DIM_DEF        = 1024;
  localparam int unsigned EXP_TABLE_BITS_DEF = 8;
  localparam int unsigned FIFO_DEPTH_DEF     = 4;

  localparam int unsigned ACC_W    = 48;  // distance sum, 16 fraction bits
  localparam int unsigned GAMMA_W  = 32;  // gamma, unsigned Q16.16
  localparam int unsigned KERNEL_W = 16;  // result, unsigned Q1.15
  localparam int unsigned SPLIT_W  = 24;  // sum split point for the two products
  localparam int unsigned HI_W     = ACC_W - SPLIT_W + GAMMA_W;
  localparam int unsigned LO_W     = SPLIT_W + GAMMA_W;
  localparam int unsigned T_SHIFT  = SPLIT_W - 16;
  localparam int unsigned T_W      = GAMMA_W + T_SHIFT + 1;
  localparam int unsigned T_LIM_W  = 20;  // t >= 16.0 in Q.16 flushes to zero

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(32'h0001_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TSUM,
    ST_LUT,
    ST_INTERP
  } rbf_state_e;

  // Per-item classification from the front end.
  typedef struct packed {
    logic use_pair;  // pair falls within the dimension limit
    logic last;      // closes the vector
  } rbf_flags_t;

  // Q1.15 sample of exp(-t) at t = idx * 16 / 2^tab_bits, built in Q0.32.
  function automatic logic [15:0] exp_sample(int unsigned tab_bits, int unsigned idx);
    logic [63:0] s;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] cur;
    s    = 64'd1 << 24;
    acc  = 64'd1 << 32;
    term = 64'd1 << 32;
    cur  = 64'd1 << 32;
    for (int unsigned n = 1; n <= 6; n++) begin
      term = (term * s) >> 32;
      case (n)
        2: term = term / 64'd2;
        3: term = term / 64'd3;
        4: term = term / 64'd4;
        5: term = term / 64'd5;
        6: term = term / 64'd6;
        default: term = term;
      endcase
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    base = acc;
    for (int unsigned k = tab_bits; k < 12; k++) begin
      base = (base * base + (64'd1 << 31)) >> 32;
    end
    for (int unsigned j = 0; j < idx; j++) begin
      cur = (cur * base + (64'd1 << 31)) >> 32;
    end
    return 16'((cur + (64'd1 << 16)) >> 17);
  endfunction

endpackage

/* design/rbf_front.sv */
// Front end: takes element pairs, squares the difference and tags each pair.
module rbf_front #(
  parameter int unsigned ELEM_BITS = rbf_pkg::ELEM_BITS_DEF,
  parameter int unsigned MAX_DIM   = rbf_pkg::MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [ELEM_BITS-1:0]     x_elem_i,
  input  logic [ELEM_BITS-1:0]     y_elem_i,
  input  logic                     last_i,
  input  logic                     space_i,
  output logic                     in_ready_o,
  output logic                     push_o,
  output logic [2*ELEM_BITS-1:0]   sq_o,
  output rbf_pkg::rbf_flags_t      flags_o
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM + 1);

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [ELEM_BITS:0] diff;
  logic [ELEM_BITS:0]       mag_wide;
  logic [ELEM_BITS-1:0]     mag;
  logic                     use_pair;

  assign in_ready_o = space_i;
  assign push_o     = in_valid_i & space_i;

  assign diff     = $signed({x_elem_i[ELEM_BITS-1], x_elem_i})
                  - $signed({y_elem_i[ELEM_BITS-1], y_elem_i});
  assign mag_wide = diff[ELEM_BITS] ? (~diff + 1'b1) : diff;
  assign mag      = mag_wide[ELEM_BITS-1:0];
  assign sq_o     = (2*ELEM_BITS)'(mag) * (2*ELEM_BITS)'(mag);

  // pairs past the dimension limit are passed on but not summed
  assign use_pair         = cnt_q < CNT_W'(MAX_DIM);
  assign flags_o.use_pair = use_pair;
  assign flags_o.last     = last_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (use_pair) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/rbf_fifo.sv */
// Short queue between front and back ends.
`include "gaussian_rbf_kernel_eval_macros.svh"
module rbf_fifo #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = rbf_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             not_empty_o,
  output logic             not_full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign not_empty_o = count_q != '0;
  assign not_full_o  = count_q != CNT_W'(DEPTH);
  assign data_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  `RBF_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && count_q == CNT_W'(DEPTH), "push into full queue")
  `RBF_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && count_q == '0, "pop from empty queue")

endmodule

/* design/rbf_back.sv */
// Back end: saturating distance sum, gamma scaling and exp table interpolation.
`include "gaussian_rbf_kernel_eval_macros.svh"
module rbf_back #(
  parameter int unsigned ELEM_BITS      = rbf_pkg::ELEM_BITS_DEF,
  parameter int unsigned EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [rbf_pkg::GAMMA_W-1:0]         gamma_i,
  input  logic                                avail_i,
  input  logic [2*ELEM_BITS-1:0]              sq_i,
  input  rbf_pkg::rbf_flags_t                 flags_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rbf_pkg::KERNEL_W-1:0]        kernel_value_o,
  output logic                                saturated_o
);

  localparam int unsigned SQ_W     = 2 * ELEM_BITS;
  localparam int unsigned ACC_W    = rbf_pkg::ACC_W;
  localparam int unsigned SUM_W    = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;
  localparam int unsigned SEG      = rbf_pkg::T_LIM_W - EXP_TABLE_BITS;
  localparam int unsigned TAB_SIZE = (1 << EXP_TABLE_BITS) + 1;
  localparam int unsigned IDX_W    = EXP_TABLE_BITS + 1;
  localparam int unsigned KW       = rbf_pkg::KERNEL_W;
  localparam int unsigned PROD_W   = KW + SEG + 1;

  rbf_pkg::rbf_state_e state_q, state_d;

  logic [ACC_W-1:0]            sum_q, sum_fin_q, acc_next;
  logic                        sat_q, sat_fin_q, sat_next;
  logic [SUM_W-1:0]            sum_wide;
  logic                        over;
  logic [rbf_pkg::HI_W-1:0]    hi_q;
  logic [rbf_pkg::LO_W-1:0]    lo_q;
  logic [rbf_pkg::T_W-1:0]     t_d, t_q;
  logic                        uflow_q;
  logic [KW-1:0]               a_q, b_q, tab_a, tab_b;
  logic [SEG-1:0]              fr_q;
  logic [EXP_TABLE_BITS-1:0]   seg_idx;
  logic [KW-1:0]               diff_ab;
  logic [PROD_W-1:0]           rnd;
  logic [KW-1:0]               kernel_calc;
  logic                        load_out;
  logic                        out_valid_q;
  logic [KW-1:0]               kernel_q;
  logic                        sat_out_q;
  logic [KW-1:0]               tab_w [TAB_SIZE];

  for (genvar g = 0; g < TAB_SIZE; g++) begin : g_tab
    assign tab_w[g] = rbf_pkg::exp_sample(EXP_TABLE_BITS, g);
  end

  // saturating accumulate
  assign sum_wide = SUM_W'(sum_q) + SUM_W'(sq_i);
  assign over     = sum_wide > {{(SUM_W - ACC_W){1'b0}}, {ACC_W{1'b1}}};
  assign acc_next = !flags_i.use_pair ? sum_q :
                    over ? {ACC_W{1'b1}} : sum_wide[ACC_W-1:0];
  assign sat_next = sat_q | (flags_i.use_pair & over);

  // t = floor(sum * gamma / 2^16), from the two partial products
  assign t_d = {1'b0, hi_q[rbf_pkg::GAMMA_W-1:0], {rbf_pkg::T_SHIFT{1'b0}}}
             + rbf_pkg::T_W'(lo_q[rbf_pkg::LO_W-1:16]);

  assign seg_idx = t_q[rbf_pkg::T_LIM_W-1:SEG];
  assign tab_a   = tab_w[{1'b0, seg_idx}];
  assign tab_b   = tab_w[IDX_W'(seg_idx) + 1'b1];

  assign diff_ab     = (a_q > b_q) ? a_q - b_q : '0;
  assign rnd         = PROD_W'(diff_ab) * PROD_W'(fr_q) + PROD_W'(1 << (SEG - 1));
  assign kernel_calc = uflow_q ? '0 : a_q - rnd[SEG+KW-1:SEG];

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbf_pkg::ST_IDLE: begin
        if (avail_i && flags_i.last) begin
          state_d = rbf_pkg::ST_MUL;
        end
      end
      rbf_pkg::ST_MUL:    state_d = rbf_pkg::ST_TSUM;
      rbf_pkg::ST_TSUM:   state_d = rbf_pkg::ST_LUT;
      rbf_pkg::ST_LUT:    state_d = rbf_pkg::ST_INTERP;
      rbf_pkg::ST_INTERP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = rbf_pkg::ST_IDLE;
        end
      end
      default: state_d = rbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      rbf_pkg::ST_IDLE:   pop_o    = avail_i;
      rbf_pkg::ST_INTERP: load_out = !out_valid_q || out_ready_i;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbf_pkg::ST_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        sum_q <= flags_i.last ? '0 : acc_next;
        sat_q <= flags_i.last ? 1'b0 : sat_next;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && flags_i.last) begin
      sum_fin_q <= acc_next;
      sat_fin_q <= sat_next;
    end
    if (state_q == rbf_pkg::ST_MUL) begin
      hi_q <= rbf_pkg::HI_W'(sum_fin_q[ACC_W-1:rbf_pkg::SPLIT_W])
            * rbf_pkg::HI_W'(gamma_i);
      lo_q <= rbf_pkg::LO_W'(sum_fin_q[rbf_pkg::SPLIT_W-1:0])
            * rbf_pkg::LO_W'(gamma_i);
    end
    if (state_q == rbf_pkg::ST_TSUM) begin
      t_q     <= t_d;
      uflow_q <= (hi_q[rbf_pkg::HI_W-1:rbf_pkg::GAMMA_W] != '0)
              || (t_d[rbf_pkg::T_W-1:rbf_pkg::T_LIM_W] != '0);
    end
    if (state_q == rbf_pkg::ST_LUT) begin
      a_q  <= tab_a;
      b_q  <= tab_b;
      fr_q <= t_q[SEG-1:0];
    end
    if (load_out) begin
      kernel_q  <= kernel_calc;
      sat_out_q <= sat_fin_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kernel_value_o = kernel_q;
  assign saturated_o    = sat_out_q;

  `RBF_ASSERT(a_last_starts_eval, clk_i, rst_ni, (pop_o && flags_i.last) |=> (state_q == rbf_pkg::ST_MUL), "last pair did not start evaluation")
  `RBF_ASSERT(a_sum_frozen, clk_i, rst_ni, (state_q != rbf_pkg::ST_IDLE) |=> $stable(sum_q), "sum changed during evaluation")
  `RBF_ASSERT(a_uflow_zero, clk_i, rst_ni, (load_out && uflow_q) |=> (kernel_q == '0), "underflow not flushed to zero")

endmodule

/* design/gaussian_rbf_kernel_eval.sv */
// Gaussian RBF kernel evaluator top level: exp(-gamma * |x - y|^2) over streamed pairs.
// A last pair's result appears on the master side once the interpolate step loads it.
// Throughput: one pair per cycle while the queue has space; each last pair holds the back end
//   (sum, gamma multiply, t sum, table read, interpolate), buffered by a 4-entry queue.
// Reset (async, active low): sum, flags, counters and queue clear; gamma returns to 1.0.
// The exp table is constant logic and needs no fill after reset.
module gaussian_rbf_kernel_eval #(
  parameter int unsigned ELEM_BITS      = rbf_pkg::ELEM_BITS_DEF,
  parameter int unsigned MAX_DIM        = rbf_pkg::MAX_DIM_DEF,
  parameter int unsigned EXP_TABLE_BITS = rbf_pkg::EXP_TABLE_BITS_DEF,
  parameter int unsigned FIFO_DEPTH     = rbf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // gamma_scale, unsigned Q16.16
  input  logic                             gamma_scale_we_i,
  input  logic [rbf_pkg::GAMMA_W-1:0]      gamma_scale_i,
  // request in
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [ELEM_BITS-1:0] x_elem, [2*ELEM_BITS-1:ELEM_BITS] y_elem, upper bits zero fill
  input  logic [((2*ELEM_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                             s_axis_tlast,
  // result out
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] kernel_value
  output logic [rbf_pkg::KERNEL_W-1:0]     m_axis_tdata,
  // [0] saturated
  output logic                             m_axis_tuser
);

  localparam int unsigned SQ_W   = 2 * ELEM_BITS;
  localparam int unsigned ENTRY_W = SQ_W + $bits(rbf_pkg::rbf_flags_t);

  logic [rbf_pkg::GAMMA_W-1:0] gamma_q;

  // front -> queue
  logic                   push;
  logic [SQ_W-1:0]        push_sq;
  rbf_pkg::rbf_flags_t    push_flags;
  logic                   q_not_full;

  // queue -> back
  logic                   q_not_empty;
  logic                   pop;
  logic [ENTRY_W-1:0]     q_data;
  rbf_pkg::rbf_flags_t    pop_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= rbf_pkg::GAMMA_RESET;
    end else if (gamma_scale_we_i) begin
      gamma_q <= gamma_scale_i;
    end
  end

  // Front end: square of the difference and dimension-limit tag per request.
  rbf_front #(
    .ELEM_BITS (ELEM_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .x_elem_i   (s_axis_tdata[ELEM_BITS-1:0]),
    .y_elem_i   (s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .last_i     (s_axis_tlast),
    .space_i    (q_not_full),
    .in_ready_o (s_axis_tready),
    .push_o     (push),
    .sq_o       (push_sq),
    .flags_o    (push_flags)
  );

  // Decoupling queue: the front keeps taking pairs while the back evaluates.
  rbf_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      ({push_sq, push_flags}),
    .pop_i       (pop),
    .data_o      (q_data),
    .not_empty_o (q_not_empty),
    .not_full_o  (q_not_full)
  );

  assign pop_flags = q_data[$bits(rbf_pkg::rbf_flags_t)-1:0];

  // Back end: accumulate, then scale and interpolate exp(-t) on the last pair.
  rbf_back #(
    .ELEM_BITS      (ELEM_BITS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .gamma_i        (gamma_q),
    .avail_i        (q_not_empty),
    .sq_i           (q_data[ENTRY_W-1:$bits(rbf_pkg::rbf_flags_t)]),
    .flags_i        (pop_flags),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .kernel_value_o (m_axis_tdata),
    .saturated_o    (m_axis_tuser)
  );

endmodule
